FILE: rtl/serial_frame_receiver_core_macros.svh
// ---------------------------------------------------------------------------
// serial frame receiver assertion macros
// shared property shorthands, clocked on clk_i and gated by rst_ni
// ---------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_CORE_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_CORE_MACROS_SVH

// same-cycle implication
`define SFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sfr_pkg.sv
// ---------------------------------------------------------------------------
// sfr_pkg
// types and constants of the serial frame receiver
// ---------------------------------------------------------------------------
package sfr_pkg;

  // framing bytes
  localparam logic [7:0] HdrByte   = 8'h5F;
  localparam logic [7:0] FlagCheck = 8'h01;

  // receive phase, one-hot
  typedef enum logic [11:0] {
    PH_HUNT    = 12'b0000_0000_0001,
    PH_FLAG    = 12'b0000_0000_0010,
    PH_CHK_HI  = 12'b0000_0000_0100,
    PH_CHK_LO  = 12'b0000_0000_1000,
    PH_CNT_HI  = 12'b0000_0001_0000,
    PH_CNT_LO  = 12'b0000_0010_0000,
    PH_LEN0    = 12'b0000_0100_0000,
    PH_LEN1    = 12'b0000_1000_0000,
    PH_LEN2    = 12'b0001_0000_0000,
    PH_PAYLOAD = 12'b0010_0000_0000,
    PH_CK1     = 12'b0100_0000_0000,
    PH_CK2     = 12'b1000_0000_0000
  } phase_e;

  // result kinds
  typedef enum logic [2:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_OK       = 3'd1,
    KIND_OK_ZERO  = 3'd2,
    KIND_BAD_SUM  = 3'd3,
    KIND_MATCH    = 3'd4,
    KIND_MISMATCH = 3'd5,
    KIND_TOO_LONG = 3'd6
  } kind_e;

  // one input beat
  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [15:0] expected_counter;
  } item_t;

  // one result beat
  typedef struct packed {
    kind_e       out_kind;
    logic [7:0]  out_byte;
    logic [15:0] frame_counter;
    logic        last;
  } result_t;

endpackage

FILE: rtl/sfr_in_if.sv
// ---------------------------------------------------------------------------
// sfr_in_if
// received byte channel: valid/ready plus byte and expected counter
// ---------------------------------------------------------------------------
interface sfr_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [15:0] expected_counter;

  modport source (output valid, output rx_byte, output expected_counter, input ready);
  modport sink   (input valid, input rx_byte, input expected_counter, output ready);
endinterface

FILE: rtl/sfr_out_if.sv
// ---------------------------------------------------------------------------
// sfr_out_if
// result channel: valid/ready plus kind, byte, counter and last flag
// ---------------------------------------------------------------------------
interface sfr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_kind;
  logic [7:0]  out_byte;
  logic [15:0] frame_counter;
  logic        last;

  modport source (output valid, output out_kind, output out_byte, output frame_counter,
                  output last, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input frame_counter,
                  input last, output ready);
endinterface

FILE: rtl/serial_frame_receiver_core.sv
// ---------------------------------------------------------------------------
// serial_frame_receiver_core
// deframes a received byte stream into payload beats and frame status
// ---------------------------------------------------------------------------
// in_i carries one received byte per beat with the transmit counter to
// compare against check frames. out_o carries zero or one beat per input
// beat: a payload byte, or a final status (last high) closing a frame.
// An input beat is registered on acceptance, processed by the deframer once
// the result register has room, and its result is registered there to show
// on out_o. Throughput is one byte per cycle while out_o is ready; the
// running frame state (phase, fields, checksums) updates once per byte.
// Reset clears the frame state to header hunt and empties both registers.
// When the sink stalls, the result register holds its beat; the input
// register takes a byte only while empty; further bytes wait at in_i.ready.
// ---------------------------------------------------------------------------
module serial_frame_receiver_core
  import sfr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sfr_in_if.sink        in_i,
  sfr_out_if.source     out_o
);

  item_t   in_item;
  item_t   hold_item;
  logic    hold_vld;
  logic    take;
  logic    room;
  logic    res_vld;
  result_t res;
  result_t out_res;

  assign in_item = '{rx_byte: in_i.rx_byte, expected_counter: in_i.expected_counter};

  // input register
  sfr_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_item_i   (in_item),
    .in_ready_o  (in_i.ready),
    .hold_vld_o  (hold_vld),
    .hold_item_o (hold_item),
    .take_i      (take)
  );

  // frame state machine
  sfr_deframer #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_deframer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_vld_i (hold_vld),
    .item_i     (hold_item),
    .room_i     (room),
    .take_o     (take),
    .res_vld_o  (res_vld),
    .res_o      (res)
  );

  // result register
  sfr_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .res_vld_i   (res_vld),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_o.valid),
    .out_res_o   (out_res),
    .out_ready_i (out_o.ready)
  );

  assign out_o.out_kind      = out_res.out_kind;
  assign out_o.out_byte      = out_res.out_byte;
  assign out_o.frame_counter = out_res.frame_counter;
  assign out_o.last          = out_res.last;

endmodule

FILE: rtl/sfr_in_stage.sv
// ---------------------------------------------------------------------------
// sfr_in_stage
// input register holding one received beat until the deframer takes it
// ---------------------------------------------------------------------------
module sfr_in_stage
  import sfr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  item_t in_item_i,
  output logic  in_ready_o,
  output logic  hold_vld_o,
  output item_t hold_item_o,
  input  logic  take_i
);

  logic  vld_q, vld_d;
  item_t item_q;

  // free when empty or emptied this cycle
  assign in_ready_o = !vld_q || take_i;
  assign vld_d      = in_ready_o ? in_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // beat payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign hold_vld_o  = vld_q;
  assign hold_item_o = item_q;

endmodule

FILE: rtl/sfr_deframer.sv
// ---------------------------------------------------------------------------
// sfr_deframer
// header hunt, field capture, checksums and status for one byte per cycle while the result register has room
// ---------------------------------------------------------------------------
`include "serial_frame_receiver_core_macros.svh"

module sfr_deframer
  import sfr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 4096
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_vld_i,
  input  item_t   item_i,
  input  logic    room_i,
  output logic    take_o,
  output logic    res_vld_o,
  output result_t res_o
);

  localparam logic [23:0] MaxLen = 24'(MAX_PAYLOAD);

  phase_e      phase_q, phase_d;
  logic [1:0]  run_q, run_d;
  logic [15:0] counter_q, counter_d;
  logic [23:0] len_q, len_d;
  logic [7:0]  idx_q, idx_d;
  logic [7:0]  wsum_q, wsum_d;
  logic [7:0]  psum_q, psum_d;
  logic [7:0]  first_q, first_d;

  logic [7:0]  b;
  logic [7:0]  idx_inc;
  logic [7:0]  wprod;
  logic [1:0]  run_inc;
  logic [23:0] len_full;
  logic [15:0] cnt_full;
  kind_e       kind;
  logic        emit;
  logic        last;
  logic [7:0]  obyte;

  assign b        = item_i.rx_byte;
  assign idx_inc  = idx_q + 8'd1;
  assign wprod    = 8'(b * idx_inc);
  assign run_inc  = run_q + 2'd1;
  assign len_full = {len_q[23:8], b};
  assign cnt_full = {counter_q[15:8], b};

  // next state and result for the held byte
  always_comb begin
    phase_d   = phase_q;
    run_d     = run_q;
    counter_d = counter_q;
    len_d     = len_q;
    idx_d     = idx_q;
    wsum_d    = wsum_q;
    psum_d    = psum_q;
    first_d   = first_q;
    kind      = KIND_PAYLOAD;
    emit      = 1'b0;
    last      = 1'b0;
    obyte     = 8'h00;
    unique case (phase_q)
      PH_FLAG: begin
        phase_d = (b == FlagCheck) ? PH_CHK_HI : PH_CNT_HI;
      end
      PH_CHK_HI: begin
        counter_d = {b, 8'h00};
        phase_d   = PH_CHK_LO;
      end
      PH_CHK_LO: begin
        counter_d = cnt_full;
        phase_d   = PH_HUNT;
        run_d     = 2'd0;
        emit      = 1'b1;
        last      = 1'b1;
        kind      = (cnt_full == item_i.expected_counter) ? KIND_MATCH : KIND_MISMATCH;
      end
      PH_CNT_HI: begin
        counter_d = {b, 8'h00};
        phase_d   = PH_CNT_LO;
      end
      PH_CNT_LO: begin
        counter_d = cnt_full;
        phase_d   = PH_LEN0;
      end
      PH_LEN0: begin
        len_d   = {b, 16'h0000};
        phase_d = PH_LEN1;
      end
      PH_LEN1: begin
        len_d   = {len_q[23:16], b, len_q[7:0]};
        phase_d = PH_LEN2;
      end
      PH_LEN2: begin
        len_d  = len_full;
        idx_d  = 8'h00;
        wsum_d = 8'h00;
        psum_d = 8'h00;
        if (len_full > MaxLen) begin
          phase_d = PH_HUNT;
          run_d   = 2'd0;
          emit    = 1'b1;
          last    = 1'b1;
          kind    = KIND_TOO_LONG;
        end else begin
          phase_d = (len_full == 24'd0) ? PH_CK1 : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        idx_d  = idx_inc;
        wsum_d = wsum_q + wprod;
        psum_d = psum_q + b;
        len_d  = len_q - 24'd1;
        if (len_q == 24'd1) begin
          phase_d = PH_CK1;
        end
        emit  = 1'b1;
        obyte = b;
      end
      PH_CK1: begin
        first_d = b;
        phase_d = PH_CK2;
      end
      PH_CK2: begin
        phase_d = PH_HUNT;
        run_d   = 2'd0;
        emit    = 1'b1;
        last    = 1'b1;
        if ((first_q != wsum_q) || (b != psum_q)) begin
          kind = KIND_BAD_SUM;
        end else begin
          kind = (counter_q == 16'h0000) ? KIND_OK_ZERO : KIND_OK;
        end
      end
      // header hunt, also recovers from a corrupt phase code
      default: begin
        phase_d = PH_HUNT;
        if (b == HdrByte) begin
          if (run_inc == 2'd3) begin
            run_d   = 2'd0;
            phase_d = PH_FLAG;
          end else begin
            run_d = run_inc;
          end
        end else begin
          run_d = 2'd0;
        end
      end
    endcase
  end

  // advance only when the result register can take the outcome
  assign take_o    = item_vld_i && room_i;
  assign res_vld_o = emit;
  assign res_o     = '{out_kind: kind, out_byte: obyte, frame_counter: counter_d, last: last};

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      run_q   <= 2'd0;
    end else if (take_o) begin
      phase_q <= phase_d;
      run_q   <= run_d;
    end
  end

  // frame fields and running sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q <= 16'h0000;
      len_q     <= 24'h000000;
      idx_q     <= 8'h00;
      wsum_q    <= 8'h00;
      psum_q    <= 8'h00;
      first_q   <= 8'h00;
    end else if (take_o) begin
      counter_q <= counter_d;
      len_q     <= len_d;
      idx_q     <= idx_d;
      wsum_q    <= wsum_d;
      psum_q    <= psum_d;
      first_q   <= first_d;
    end
  end

  // checks
  `SFR_ASSERT_IMP(a_nonlast_is_payload, res_vld_o && !res_o.last, res_o.out_kind == KIND_PAYLOAD, "non-final beat must carry payload")
  `SFR_ASSERT_IMP(a_status_byte_zero, res_vld_o && (res_o.out_kind != KIND_PAYLOAD), res_o.out_byte == 8'h00, "status beat must carry a zero byte")
  `SFR_ASSERT_NXT(a_length_end, take_o && (phase_q == PH_PAYLOAD) && (len_q == 24'd1), phase_q == PH_CK1, "payload end must move to checksum")
  `SFR_ASSERT_NXT(a_status_rehunt, take_o && res_vld_o && res_o.last, (phase_q == PH_HUNT) && (run_q == 2'd0), "final status must restart the hunt")

endmodule

FILE: rtl/sfr_out_stage.sv
// ---------------------------------------------------------------------------
// sfr_out_stage
// result register driving the output channel
// ---------------------------------------------------------------------------
module sfr_out_stage
  import sfr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  logic    res_vld_i,
  input  result_t res_i,
  output logic    room_o,
  output logic    out_valid_o,
  output result_t out_res_o,
  input  logic    out_ready_i
);

  logic    vld_q, vld_d;
  result_t res_q;

  // room when empty or the current beat leaves now
  assign room_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = res_vld_i;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_i && res_vld_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_res_o   = res_q;

endmodule
